// ===== rtl/core/ttrdc_pkg.sv =====
package ttrdc_pkg;

  // Default panel geometry in tiles.
  localparam int unsigned TileRowsDefault = 4;
  localparam int unsigned TileColsDefault = 16;

  // Glyph and tile geometry.
  localparam int unsigned GlyphWidth  = 5;
  localparam int unsigned GlyphHeight = 7;
  localparam int unsigned BlockSize   = 8;
  localparam int unsigned TileBits    = BlockSize * BlockSize;
  localparam int unsigned GlyphBits   = GlyphWidth * GlyphHeight;

  typedef logic [TileBits-1:0]  tile_t;
  typedef logic [GlyphBits-1:0] glyph_t;

  // Font ROM: seven row patterns, top row first, bit 4 of a row is the left pixel.
  function automatic glyph_t glyph_rows(input logic [7:0] code);
    glyph_t rows;
    case (code)
      8'h25:   rows = {5'h19, 5'h19, 5'h02, 5'h04, 5'h08, 5'h13, 5'h13};
      8'h3A:   rows = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
      8'h30:   rows = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
      8'h31:   rows = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
      8'h32:   rows = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
      8'h33:   rows = {5'h1f, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0e};
      8'h34:   rows = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
      8'h35:   rows = {5'h1f, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h11, 5'h0e};
      8'h36:   rows = {5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
      8'h37:   rows = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8'h38:   rows = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
      8'h39:   rows = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h1c};
      8'h41:   rows = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
      8'h43:   rows = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
      8'h46:   rows = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h4C:   rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
      8'h4D:   rows = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
      8'h4E:   rows = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
      8'h4F:   rows = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h50:   rows = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
      8'h52:   rows = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
      8'h54:   rows = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      8'h55:   rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
      8'h59:   rows = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
      // Space and every code without a glyph draw blank.
      default: rows = '0;
    endcase
    return rows;
  endfunction

  // Turns a glyph into a column-major tile; glyph column c lands in byte c+1.
  function automatic tile_t render_tile(input logic [7:0] code);
    glyph_t rows;
    tile_t  tile;
    rows = glyph_rows(code);
    tile = '0;
    for (int r = 0; r < GlyphHeight; r++) begin
      for (int c = 0; c < GlyphWidth; c++) begin
        tile[BlockSize*(c+1)+r] =
          rows[(GlyphHeight-1-r)*GlyphWidth + (GlyphWidth-1-c)];
      end
    end
    return tile;
  endfunction

endpackage

// ===== rtl/core/tile_text_renderer_dirty_cache_core.sv =====
// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_ready_o   tile_row_i, tile_col_i, char_code_i, frame_end_i
// out      output     out_valid_o / out_ready_i pixel_x_o, pixel_y_o, column_bits_o
//
// One tile is accepted per cycle unless a tile write waits on a stalled output; a tile
// write moves from the input stage to the output register, waiting while the output stalls.
// The cache memory read is registered together with the input stage.
// Reset clears the stage valid flags and the primed flag; the tile cache is not cleared.
// A stalled output holds back only a tile that must be written; unchanged tiles drain.
module tile_text_renderer_dirty_cache_core
  import ttrdc_pkg::*;
#(
  parameter int unsigned TILE_ROWS = TileRowsDefault,
  parameter int unsigned TILE_COLS = TileColsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  tile_row_i,
  input  logic [3:0]  tile_col_i,
  input  logic [7:0]  char_code_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  pixel_x_o,
  output logic [4:0]  pixel_y_o,
  output logic [63:0] column_bits_o
);

  localparam int unsigned Depth = TILE_ROWS * TILE_COLS;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Tile cache memory, one entry per tile.
  tile_t cache_mem [Depth];

  logic            in_accept;
  logic            in_grid_in;
  logic [IdxW-1:0] idx_in;

  logic            s1_valid_q, s1_valid_d;
  logic            s1_grid_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [1:0]      s1_row_q;
  logic [3:0]      s1_col_q;
  tile_t           s1_tile_q;
  logic            s1_last_q;
  tile_t           rd_data_q;
  logic            byp_hit_q;
  tile_t           byp_data_q;
  tile_t           cached;
  logic            s1_emit;
  logic            s1_adv;

  logic            primed_q, primed_d;
  logic            out_valid_q, out_valid_d;
  logic [6:0]      pixel_x_q;
  logic [4:0]      pixel_y_q;
  tile_t           column_bits_q;

  // Grid check and cache index of the incoming tile.
  assign in_grid_in = (32'(tile_row_i) < 32'(TILE_ROWS)) && (32'(tile_col_i) < 32'(TILE_COLS));
  assign idx_in     = IdxW'(32'(tile_row_i) * 32'(TILE_COLS) + 32'(tile_col_i));

  // The stage moves on when its tile needs no output slot or a slot is free.
  assign cached     = byp_hit_q ? byp_data_q : rd_data_q;
  assign s1_emit    = s1_grid_q && (!primed_q || (s1_tile_q != cached));
  assign s1_adv     = s1_valid_q && (!s1_emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // Next values of the control registers.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    primed_d = primed_q || (s1_adv && s1_last_q);
    out_valid_d = out_valid_q;
    if (s1_adv && s1_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      primed_q    <= primed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input stage with the rendered tile, the cache read and a bypass for a write
  // to the same tile in the same cycle.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_grid_q  <= in_grid_in;
      s1_idx_q   <= idx_in;
      s1_row_q   <= tile_row_i;
      s1_col_q   <= tile_col_i;
      s1_tile_q  <= render_tile(char_code_i);
      s1_last_q  <= frame_end_i;
      rd_data_q  <= cache_mem[idx_in];
      byp_hit_q  <= s1_adv && s1_emit && (s1_idx_q == idx_in);
      byp_data_q <= s1_tile_q;
    end
  end

  // Cache update for every tile that is written out.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      cache_mem[s1_idx_q] <= s1_tile_q;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      pixel_x_q     <= {s1_col_q, 3'b000};
      pixel_y_q     <= {s1_row_q, 3'b000};
      column_bits_q <= s1_tile_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = pixel_x_q;
  assign pixel_y_o     = pixel_y_q;
  assign column_bits_o = column_bits_q;

  // The primed flag never drops once set.
  assert property (@(posedge clk_i) disable iff (!rst_ni) primed_q |=> primed_q)
    else $error("cache primed flag dropped");

  // Tile bytes outside the glyph columns are always blank.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (column_bits_o[7:0] == 8'h00) && (column_bits_o[63:48] == 16'h0000))
    else $error("tile write has bits outside the glyph columns");

  // A tile waiting for a stalled output blocks new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_emit && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while the stage is blocked");

  // A transfer in always fills the input stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_accept |=> s1_valid_q)
    else $error("accepted tile lost from the input stage");

endmodule
